// ===== sv/lurf_pkg.sv =====
package lurf_pkg;

  localparam int CHAR_W       = 8;
  localparam int NUM_CHARS    = 1 << CHAR_W;
  localparam int BEST_START_W = 16;
  localparam int BEST_LEN_W   = 17;
  localparam int IN_DATA_W    = 8;
  // best_start + best_length + overflow = 34 bits, padded to 5 bytes
  localparam int OUT_DATA_W   = 40;
  localparam int FIFO_DEPTH   = 3;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 2;

  // control side of the seen-table write port
  typedef struct packed {
    logic              en;    // record a position for addr
    logic              clr;   // drop every valid bit (end of string)
    logic [CHAR_W-1:0] addr;
  } seen_wr_t;

endpackage

// ===== sv/lurf_seen_mem.sv =====
module lurf_seen_mem
  import lurf_pkg::*;
#(
  parameter int PW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] rd_addr,
  output logic [PW-1:0]     rd_pos,
  output logic              rd_vld,
  input  seen_wr_t          wr,
  input  logic [PW-1:0]     wr_pos
);

  logic [PW-1:0]        pos_mem [NUM_CHARS];
  logic [NUM_CHARS-1:0] vld_r;
  logic [PW-1:0]        rd_pos_r;
  logic                 rd_vld_r;

  // position store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pos_mem[wr.addr] <= wr_pos;
    end
    rd_pos_r <= pos_mem[rd_addr];
  end

  // valid bits; clear wins over a same-cycle set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr.clr) begin
        vld_r <= '0;
      end else if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_pos = rd_pos_r;
  assign rd_vld = rd_vld_r;

endmodule

// ===== sv/lurf_out_fifo.sv =====
module lurf_out_fifo
  import lurf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [OUT_DATA_W-1:0] push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [FIFO_CNT_W-1:0] cnt
);

  logic [OUT_DATA_W-1:0] buf_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = buf_mem[rd_ptr_r];
  assign cnt       = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/longest_unique_run_finder_unit.sv =====
// Longest unique run finder.
// Input stream: one byte of a string per beat on in_tdata[7:0]; in_tlast
// marks the final byte. Output stream: one beat per string, carrying the
// start position and length of the earliest longest run with no repeated
// byte, plus an overflow flag when the string ran past MAX_LEN bytes
// (bytes beyond MAX_LEN are ignored; the result covers the first MAX_LEN).
// Throughput: one byte per cycle while in_tready is high, strings back to
// back. The per-byte work is one read and one write of a 256-entry position
// table; the table read is registered and a write forward covers a repeat
// of the byte just before.
// The result beat passes the stage-1 register and the result buffer
// before it shows on out_tvalid.
// Stall: results queue in a three-beat buffer; in_tready drops only when
// that buffer could not take the result of one more string.
// Reset: rst_n (sync, low) clears all valid bits, window and best state;
// no clearing pass. The block also clears itself after each last byte,
// so the next beat starts a new string.
module longest_unique_run_finder_unit
  import lurf_pkg::*;
#(
  parameter int MAX_LEN = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_in
  input  logic                  in_tlast,   // last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [15:0] best_start, [32:16] best_length,
                                            // [33] overflow, [39:34] zero
);

  localparam int PW = $clog2(MAX_LEN);      // stored positions, < MAX_LEN
  localparam int CW = $clog2(MAX_LEN + 1);  // counts up to MAX_LEN

  // stage 1: byte whose table read is in flight
  logic              s1_v_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;

  // string state
  logic [PW-1:0] ws_r, ws_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] best_start_r, best_start_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt;
  logic          ovf_r, ovf_nxt;

  // forward of the write done at the previous edge
  logic              fwd_v_r;
  logic [CHAR_W-1:0] fwd_addr_r;
  logic [PW-1:0]     fwd_pos_r;
  logic              clr_seen_r;   // valid bits cleared at the previous edge

  logic              in_fire;
  seen_wr_t          seen_wr;
  logic [PW-1:0]     rd_pos;
  logic              rd_vld;

  logic              hit_fwd, hit_vld, over, take, better, s1_end;
  logic [PW-1:0]     hit_pos, cur_pos, ws_upd;
  logic [CW-1:0]     run_len;

  logic [PW-1:0]         res_start;
  logic [CW-1:0]         res_len;
  logic [31:0]           start_ext, len_ext;
  logic [OUT_DATA_W-1:0] res_data;

  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   pending;

  // accept while the buffer has room for this string's result and for one
  // already in stage 1
  assign pending   = {1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(s1_v_r & s1_last_r);
  assign in_tready = (pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign in_fire   = in_tvalid & in_tready;

  lurf_seen_mem #(
    .PW (PW)
  ) u_seen (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (in_tdata[CHAR_W-1:0]),
    .rd_pos  (rd_pos),
    .rd_vld  (rd_vld),
    .wr      (seen_wr),
    .wr_pos  (cur_pos)
  );

  // window update for the stage-1 byte
  always_comb begin
    hit_fwd = fwd_v_r && (fwd_addr_r == s1_char_r);
    hit_vld = hit_fwd | (rd_vld & ~clr_seen_r);
    hit_pos = hit_fwd ? fwd_pos_r : rd_pos;
    over    = (pos_r >= CW'(MAX_LEN));
    take    = s1_v_r & ~over;
    s1_end  = s1_v_r & s1_last_r;
    cur_pos = pos_r[PW-1:0];
    // repeat inside the window: start just past the earlier copy
    ws_upd  = (hit_vld && (hit_pos >= ws_r)) ? PW'(hit_pos + 1'b1) : ws_r;
    run_len = CW'(pos_r - CW'(ws_upd) + CW'(1));
    better  = (run_len > best_len_r);

    ws_nxt         = ws_r;
    pos_nxt        = pos_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    ovf_nxt        = ovf_r | (s1_v_r & over);
    if (take) begin
      ws_nxt  = ws_upd;
      pos_nxt = pos_r + 1'b1;
      if (better) begin
        best_start_nxt = ws_upd;
        best_len_nxt   = run_len;
      end
    end

    res_start = best_start_nxt;
    res_len   = best_len_nxt;
    start_ext = 32'(res_start);
    len_ext   = 32'(res_len);
    res_data  = {(OUT_DATA_W - BEST_START_W - BEST_LEN_W - 1)'(0), ovf_nxt,
                 len_ext[BEST_LEN_W-1:0], start_ext[BEST_START_W-1:0]};

    if (s1_end) begin
      ws_nxt         = '0;
      pos_nxt        = '0;
      best_start_nxt = '0;
      best_len_nxt   = '0;
      ovf_nxt        = 1'b0;
    end
  end

  always_comb begin
    seen_wr.en   = take;
    seen_wr.clr  = s1_end;
    seen_wr.addr = s1_char_r;
  end

  lurf_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_end),
    .push_data (res_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .cnt       (fifo_cnt)
  );

  always_ff @(posedge clk) begin
    s1_char_r  <= in_tdata[CHAR_W-1:0];
    s1_last_r  <= in_tlast;
    fwd_addr_r <= s1_char_r;
    fwd_pos_r  <= cur_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      fwd_v_r      <= 1'b0;
      clr_seen_r   <= 1'b0;
      ws_r         <= '0;
      pos_r        <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      ovf_r        <= 1'b0;
    end else begin
      s1_v_r       <= in_fire;
      fwd_v_r      <= take & ~s1_last_r;  // a last byte's entry is dropped
      clr_seen_r   <= s1_end;
      ws_r         <= ws_nxt;
      pos_r        <= pos_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |=> pos_r == '0)
    else $error("position not cleared after last byte");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(ws_r) <= pos_r)
    else $error("window start past position");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_len_r <= pos_r)
    else $error("best length exceeds bytes counted");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> (fifo_cnt != FIFO_CNT_W'(FIFO_DEPTH)) || out_tready)
    else $error("result pushed into full buffer");
`endif

endmodule

// ===== tb/longest_unique_run_finder_unit_test.sv =====
module longest_unique_run_finder_unit_test
  import lurf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_LIMIT   = 65536;      // MAX_LEN of the instance
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RAND_ITEMS  = 750;
  localparam int MIN_STRINGS = 40;         // random strings, so results keep coming
  localparam int DRAIN_WAIT  = 16;

  // how often a side sits out before its next beat
  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

  typedef logic [CHAR_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic                    ovf;
    logic [BEST_LEN_W-1:0]   length;
    logic [BEST_START_W-1:0] start;
  } run_result_t;

  // Sliding-window predictor plus queue of pending run results.
  class run_scoreboard;
    bit          seen_ok[NUM_CHARS];
    logic [16:0] seen_at[NUM_CHARS];
    logic [16:0] win_start;
    logic [16:0] pos;
    logic [16:0] best_start;
    logic [16:0] best_len;
    bit          ovf;
    run_result_t run_q[$];
    int          errors;

    function new();
      foreach (seen_at[i]) seen_at[i] = '0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (seen_ok[i]) seen_ok[i] = 1'b0;
      win_start  = '0;
      pos        = '0;
      best_start = '0;
      best_len   = '0;
      ovf        = 1'b0;
    endfunction

    function void note_byte(logic [CHAR_W-1:0] c, bit lst);
      logic [16:0] run_len;
      run_result_t r;
      if (pos >= LEN_LIMIT) begin
        ovf = 1'b1;                      // past the limit: flag only
      end else begin
        // repeat inside the window: slide start past the old copy
        if (seen_ok[c] && seen_at[c] >= win_start) win_start = seen_at[c] + 17'd1;
        seen_at[c] = pos;
        seen_ok[c] = 1'b1;
        run_len = pos - win_start + 17'd1;
        if (run_len > best_len) begin    // strictly longer: earliest tie wins
          best_start = win_start;
          best_len   = run_len;
        end
        pos = pos + 17'd1;
      end
      if (lst) begin
        r.start  = best_start[BEST_START_W-1:0];
        r.length = best_len[BEST_LEN_W-1:0];
        r.ovf    = ovf;
        run_q.push_back(r);
        clear_string();
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      run_result_t exp_r;
      run_result_t got;
      got = d[$bits(run_result_t)-1:0];
      if (run_q.size() == 0) begin
        $display("%0t: result with nothing pending, got 0x%0h", $time, d);
        errors++;
        return;
      end
      exp_r = run_q.pop_front();
      if (got.start !== exp_r.start) begin
        $display("%0t: best_start expected %0d, got %0d", $time, exp_r.start, got.start);
        errors++;
      end
      if (got.length !== exp_r.length) begin
        $display("%0t: best_length expected %0d, got %0d", $time, exp_r.length, got.length);
        errors++;
      end
      if (got.ovf !== exp_r.ovf) begin
        $display("%0t: overflow expected %0d, got %0d", $time, exp_r.ovf, got.ovf);
        errors++;
      end
      if (d[OUT_DATA_W-1:$bits(run_result_t)] !== '0) begin
        $display("%0t: pad bits expected 0, got 0x%0h", $time,
                 d[OUT_DATA_W-1:$bits(run_result_t)]);
        errors++;
      end
    endfunction

    function int pending();
      return run_q.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  run_scoreboard sb = new();
  pace_t         tx_pace = PACE_FULL;
  pace_t         rx_pace = PACE_RANDOM;
  int            cycles  = 0;
  int            rand_sent;
  int            strings_sent;

  longest_unique_run_finder_unit #(
    .MAX_LEN(LEN_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_wait(pace_t p);
    case (p)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 17);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // one input beat; returns right after the edge that took it
  task automatic send_byte(input logic [CHAR_W-1:0] c, input bit lst);
    int gap;
    gap = draw_wait(tx_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(c, lst);
  endtask

  task automatic send_string(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // result side: random stalls before each beat
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_pace = pace_t'($urandom_range(0, 2));
      stall = draw_wait(rx_pace);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    byte_q_t           str;
    int                len;
    int                alpha;
    int                pick;
    bit                sweep;
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] c;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings
    tx_pace = PACE_SPARSE;
    str = {8'h00};                                    // single byte
    send_string(str);
    str = {8'hFF, 8'hFF};                             // repeat of the byte just before
    send_string(str);
    str = {8'h55, 8'hAA, 8'hAA, 8'h55};               // old copy left of the window
    send_string(str);
    str = {8'h0F, 8'hF0, 8'h3C, 8'h0F, 8'hF0, 8'h3C}; // equal runs, earliest kept
    send_string(str);
    str = {8'h80, 8'h7F, 8'h01, 8'hFE, 8'h80};
    send_string(str);

    // random strings, back to back, varied alphabets and pacing
    rand_sent    = 0;
    strings_sent = 0;
    while (rand_sent < RAND_ITEMS || strings_sent < MIN_STRINGS) begin
      tx_pace = pace_t'($urandom_range(0, 2));
      len     = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 16);
      pick    = $urandom_range(0, 4);
      alpha   = (pick == 0) ? 2 : (pick == 1) ? 5 : (pick == 2) ? 16 : (pick == 3) ? 64 : 256;
      sweep   = ($urandom_range(0, 4) == 0);
      base    = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        if (sweep && $urandom_range(0, 15) != 0) c = base + i[7:0];
        else                                     c = base + 8'($urandom_range(0, alpha - 1));
        send_byte(c, i == len - 1);
      end
      rand_sent    += len;
      strings_sent += 1;
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
